// ===== rtl/hrd_pkg.sv =====
// Shared types, codes and constants for the HTTP response deframer.
package hrd_pkg;

  // Default width of the content-length, body and chunk counters.
  localparam int COUNT_BITS_DEF = 32;

  // Status code saturation value and the accepted success range.
  localparam logic [9:0] STATUS_MAX = 10'd1000;
  localparam logic [9:0] STATUS_OK_LO = 10'd200;
  localparam logic [9:0] STATUS_OK_HI = 10'd300;

  // Output queue depth; a power of two so pointers wrap naturally.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_NO_HEADER  = 3'd1,
    ERR_BAD_SIZE   = 3'd2,
    ERR_TRUNCATED  = 3'd3,
    ERR_BAD_STATUS = 3'd4
  } hrd_err_t;

  typedef enum logic {
    KIND_BODY = 1'b0,
    KIND_END  = 1'b1
  } hrd_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_response;
  } hrd_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] body_byte;
    logic [2:0] error_code;
    logic [9:0] http_status;
  } hrd_out_t;

  // Results of one accepted input beat, from the parser to the top level.
  typedef struct packed {
    logic       emit_body;
    logic       emit_end;
    logic [7:0] body_byte;
    logic [2:0] error_code;
    logic [9:0] http_status;
  } hrd_step_t;

endpackage

// ===== rtl/hrd_parser.sv =====
// Per-byte response parser: header scan, plain and chunked body framing.
module hrd_parser import hrd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  hrd_in_t   octet,
  output hrd_step_t result
);

  localparam int CHUNK_LEN = 26;
  localparam int LEN_LEN = 15;
  localparam logic [8*CHUNK_LEN-1:0] CHUNK_STR = "transfer-encoding: chunked";
  localparam logic [8*LEN_LEN-1:0] LEN_STR = "content-length:";
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_SP = 8'd32;
  localparam logic [7:0] CH_TAB = 8'd9;

  typedef enum logic [2:0] {
    PH_HEADER, PH_PLAIN, PH_SZ_WS, PH_SZ_HEX, PH_SZ_TAIL, PH_DATA, PH_SKIP, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    NUM_WAIT, NUM_BLANKS, NUM_DIGITS, NUM_DONE
  } num_step_t;

  function automatic logic [7:0] chunk_char(input logic [4:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (idx < 5'(CHUNK_LEN)) ch = CHUNK_STR[(CHUNK_LEN - 1 - int'(idx)) * 8 +: 8];
    return ch;
  endfunction

  function automatic logic [7:0] len_char(input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (idx < 4'(LEN_LEN)) ch = LEN_STR[(LEN_LEN - 1 - int'(idx)) * 8 +: 8];
    return ch;
  endfunction

  // Returns {valid, value}.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= "0" && c <= "9") r = {1'b1, c[3:0]};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  phase_t                  phase, phase_next;
  logic [1:0]              term_prog, term_prog_next;
  num_step_t               st_step, st_step_next;
  logic [9:0]              st_val, st_val_next;
  logic [4:0]              ch_idx, ch_idx_next;
  logic                    ch_seen, ch_seen_next;
  logic [3:0]              len_idx, len_idx_next;
  num_step_t               len_step, len_step_next;
  logic [COUNT_BITS-1:0]   len_val, len_val_next;
  logic [COUNT_BITS-1:0]   body_cnt, body_cnt_next;
  logic [COUNT_BITS-1:0]   chunk_rem, chunk_rem_next;
  logic [1:0]              skip_cnt, skip_cnt_next;

  logic [7:0]              c, lc;
  logic                    dig, blank;
  logic [3:0]              dval;
  logic [4:0]              hx;
  logic [13:0]             st_wide;
  logic [COUNT_BITS+3:0]   len_wide;
  logic [COUNT_BITS-1:0]   len_acc, hex_acc;
  logic [4:0]              ch_m;
  logic [3:0]              len_m;
  logic                    emit;
  hrd_err_t                err;

  always_comb begin
    c = octet.data_byte;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    dig = c >= "0" && c <= "9";
    blank = c == CH_SP || c == CH_TAB;
    dval = c[3:0];
    hx = hex_val(c);

    // Decimal accumulate: v*10 + d, saturating.
    st_wide = {1'b0, st_val, 3'b0} + {3'b0, st_val, 1'b0} + {10'b0, dval};
    len_wide = {1'b0, len_val, 3'b0} + {3'b0, len_val, 1'b0} + {{COUNT_BITS{1'b0}}, dval};
    len_acc = (len_wide[COUNT_BITS+3:COUNT_BITS] != 4'd0) ? COUNT_MAX
                                                         : len_wide[COUNT_BITS-1:0];
    // Hex accumulate: v*16 + h, saturating.
    hex_acc = (chunk_rem[COUNT_BITS-1 -: 4] != 4'd0) ? COUNT_MAX
                                                     : {chunk_rem[COUNT_BITS-5:0], hx[3:0]};

    ch_m = (lc == chunk_char(ch_idx)) ? ch_idx + 5'd1
                                      : ((lc == chunk_char(5'd0)) ? 5'd1 : 5'd0);
    len_m = (lc == len_char(len_idx)) ? len_idx + 4'd1
                                      : ((lc == len_char(4'd0)) ? 4'd1 : 4'd0);

    phase_next = phase;
    term_prog_next = term_prog;
    st_step_next = st_step;
    st_val_next = st_val;
    ch_idx_next = ch_idx;
    ch_seen_next = ch_seen;
    len_idx_next = len_idx;
    len_step_next = len_step;
    len_val_next = len_val;
    body_cnt_next = body_cnt;
    chunk_rem_next = chunk_rem;
    skip_cnt_next = skip_cnt;
    emit = 1'b0;
    err = ERR_OK;

    unique case (phase)
      PH_HEADER: begin
        unique case (st_step)
          NUM_WAIT: if (c == CH_SP) st_step_next = NUM_BLANKS;
          NUM_BLANKS: begin
            if (dig) begin
              st_val_next = {6'b0, dval};
              st_step_next = NUM_DIGITS;
            end else if (!blank) begin
              st_step_next = NUM_DONE;
            end
          end
          NUM_DIGITS: begin
            if (dig) st_val_next = (st_wide > 14'(STATUS_MAX)) ? STATUS_MAX : st_wide[9:0];
            else st_step_next = NUM_DONE;
          end
          default: ;
        endcase

        if (!ch_seen) begin
          if (ch_m == 5'(CHUNK_LEN)) begin
            ch_seen_next = 1'b1;
            ch_idx_next = 5'd0;
          end else begin
            ch_idx_next = ch_m;
          end
        end

        unique case (len_step)
          NUM_WAIT: begin
            if (len_m == 4'(LEN_LEN)) begin
              len_step_next = NUM_BLANKS;
              len_idx_next = 4'd0;
            end else begin
              len_idx_next = len_m;
            end
          end
          NUM_BLANKS: begin
            if (dig) begin
              len_val_next = {{(COUNT_BITS-4){1'b0}}, dval};
              len_step_next = NUM_DIGITS;
            end else if (!blank) begin
              len_step_next = NUM_DONE;
            end
          end
          NUM_DIGITS: begin
            if (dig) len_val_next = len_acc;
            else len_step_next = NUM_DONE;
          end
          default: ;
        endcase

        // CR LF CR LF tracker: even progress wants CR, odd wants LF.
        if (c == (term_prog[0] ? CH_LF : CH_CR)) begin
          if (term_prog == 2'd3) begin
            term_prog_next = 2'd0;
            if (ch_seen_next) begin
              phase_next = PH_SZ_WS;
              skip_cnt_next = 2'd0;
              chunk_rem_next = '0;
            end else begin
              phase_next = PH_PLAIN;
            end
          end else begin
            term_prog_next = term_prog + 2'd1;
          end
        end else begin
          term_prog_next = (c == CH_CR) ? 2'd1 : 2'd0;
        end
      end

      PH_PLAIN: begin
        if (len_step == NUM_WAIT || body_cnt < len_val) begin
          emit = 1'b1;
          if (body_cnt != COUNT_MAX) body_cnt_next = body_cnt + 1'b1;
        end
      end

      PH_SZ_WS, PH_SZ_HEX, PH_SZ_TAIL: begin
        skip_cnt_next = 2'd1;
        if (c == CH_LF && term_prog != 2'd0) begin
          term_prog_next = 2'd0;
          phase_next = (chunk_rem == '0) ? PH_DONE : PH_DATA;
        end else begin
          term_prog_next = (c == CH_CR) ? 2'd1 : 2'd0;
          if (phase == PH_SZ_WS) begin
            if (hx[4]) begin
              chunk_rem_next = {{(COUNT_BITS-4){1'b0}}, hx[3:0]};
              phase_next = PH_SZ_HEX;
            end else if (!blank) begin
              phase_next = PH_SZ_TAIL;
            end
          end else if (phase == PH_SZ_HEX) begin
            if (hx[4]) chunk_rem_next = hex_acc;
            else phase_next = PH_SZ_TAIL;
          end
        end
      end

      PH_DATA: begin
        emit = 1'b1;
        if (chunk_rem != '0) chunk_rem_next = chunk_rem - 1'b1;
        if (chunk_rem_next == '0) begin
          phase_next = PH_SKIP;
          skip_cnt_next = 2'd2;
        end
      end

      PH_SKIP: begin
        if (skip_cnt != 2'd0) skip_cnt_next = skip_cnt - 2'd1;
        if (skip_cnt_next == 2'd0) begin
          phase_next = PH_SZ_WS;
          term_prog_next = 2'd0;
          skip_cnt_next = 2'd0;
          chunk_rem_next = '0;
        end
      end

      default: ;
    endcase

    // Framing error from the state this byte leaves behind, then status.
    unique case (phase_next)
      PH_HEADER: err = ERR_NO_HEADER;
      PH_SZ_WS, PH_SZ_HEX, PH_SZ_TAIL: err = (skip_cnt_next != 2'd0) ? ERR_BAD_SIZE : ERR_OK;
      PH_DATA: err = ERR_TRUNCATED;
      PH_SKIP: err = (skip_cnt_next >= 2'd2) ? ERR_TRUNCATED : ERR_OK;
      default: err = ERR_OK;
    endcase
    if (err == ERR_OK && (st_val_next < STATUS_OK_LO || st_val_next >= STATUS_OK_HI))
      err = ERR_BAD_STATUS;

    result.emit_body = step && emit;
    result.emit_end = step && octet.end_of_response;
    result.body_byte = c;
    result.error_code = err;
    result.http_status = st_val_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && octet.end_of_response)) begin
      phase <= PH_HEADER;
      term_prog <= 2'd0;
      st_step <= NUM_WAIT;
      st_val <= 10'd0;
      ch_idx <= 5'd0;
      ch_seen <= 1'b0;
      len_idx <= 4'd0;
      len_step <= NUM_WAIT;
      len_val <= '0;
      body_cnt <= '0;
      chunk_rem <= '0;
      skip_cnt <= 2'd0;
    end else if (step) begin
      phase <= phase_next;
      term_prog <= term_prog_next;
      st_step <= st_step_next;
      st_val <= st_val_next;
      ch_idx <= ch_idx_next;
      ch_seen <= ch_seen_next;
      len_idx <= len_idx_next;
      len_step <= len_step_next;
      len_val <= len_val_next;
      body_cnt <= body_cnt_next;
      chunk_rem <= chunk_rem_next;
      skip_cnt <= skip_cnt_next;
    end
  end

endmodule

// ===== rtl/hrd_out_queue.sv =====
// Small result queue that takes up to two beats per cycle and gives one.
module hrd_out_queue import hrd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_a,
  input  hrd_out_t beat_a,
  input  logic     push_b,
  input  hrd_out_t beat_b,
  output logic     room,
  output logic     item_valid,
  input  logic     item_ready,
  output hrd_out_t item
);

  hrd_out_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   head, tail;
  logic [QUEUE_CNT_W-1:0]   count, count_next;
  logic                     pop;
  logic [QUEUE_PTR_W-1:0]   tail_b;

  assign pop = item_valid && item_ready;
  assign item_valid = count != '0;
  assign item = mem[head];
  assign room = count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
  assign tail_b = push_a ? tail + 1'b1 : tail;

  always_comb begin
    count_next = count + QUEUE_CNT_W'(push_a) + QUEUE_CNT_W'(push_b) - QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + 1'b1;
      tail <= tail_b + QUEUE_PTR_W'(push_b);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) mem[tail] <= beat_a;
    if (push_b) mem[tail_b] <= beat_b;
  end

endmodule

// ===== rtl/http_response_deframer_core.sv =====
// Top level of the HTTP/1.1 response deframer with chunked body decoding.
//
// Feed the received response one byte per octet beat and raise
// end_of_response on its last byte. The block emits decoded body bytes as
// item beats of kind body, and on the last byte one item of kind end that
// carries the parsed status and an error code (no header end, bad size line,
// truncated chunk, status outside 200..299); it then starts over for the
// next response. Each byte is parsed by single-cycle logic against the
// parser state registers, and its results land in a four-entry queue, so the
// block takes one byte every cycle while the consumer keeps up. octet_ready
// stays high while the queue has room for the two items one byte can cause;
// the end item is the only case where one byte yields two items. COUNT_BITS
// sets the width of the content-length, body and chunk-size counters, which
// saturate at their all-ones value.
module http_response_deframer_core import hrd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     octet_valid,
  output logic     octet_ready,
  input  hrd_in_t  octet,
  output logic     item_valid,
  input  logic     item_ready,
  output hrd_out_t item
);

  hrd_step_t result;
  hrd_out_t  body_beat, end_beat, beat_a;
  logic      step, room, push_a, push_b;

  // Advance the parser only on an accepted byte.
  assign octet_ready = room;
  assign step = octet_valid && octet_ready;

  hrd_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .octet  (octet),
    .result (result)
  );

  // Build the beats: a body beat carries zero status fields, an end beat a
  // zero byte. When both occur the body beat goes first.
  always_comb begin
    body_beat.kind = KIND_BODY;
    body_beat.body_byte = result.body_byte;
    body_beat.error_code = ERR_OK;
    body_beat.http_status = 10'd0;

    end_beat.kind = KIND_END;
    end_beat.body_byte = 8'd0;
    end_beat.error_code = result.error_code;
    end_beat.http_status = result.http_status;

    beat_a = result.emit_body ? body_beat : end_beat;
    push_a = result.emit_body || result.emit_end;
    push_b = result.emit_body && result.emit_end;
  end

  hrd_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_a     (push_a),
    .beat_a     (beat_a),
    .push_b     (push_b),
    .beat_b     (end_beat),
    .room       (room),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // The last byte of a response always leaves its end item queued.
  a_end_queued: assert property (@(posedge clk) disable iff (rst)
    octet_valid && octet_ready && octet.end_of_response |=> item_valid)
    else $error("end item missing after last byte");

  // Backpressure only comes from a queue that holds results.
  a_stall_has_items: assert property (@(posedge clk) disable iff (rst)
    !octet_ready |-> item_valid)
    else $error("input stalled with empty result queue");

  // Body items never carry status fields.
  a_body_clean: assert property (@(posedge clk) disable iff (rst)
    item_valid && item.kind == KIND_BODY |-> item.error_code == ERR_OK &&
      item.http_status == 10'd0)
    else $error("body item carries status fields");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !item_valid)
    else $error("result offered after reset");

endmodule
